// ----- rtl/core/wcp_pkg.sv -----
// Shared types, constants and helpers for the window coverage block.
// No dependencies; every other file in rtl/core refers to it by scoped names.

package wcp_pkg;

	// Field widths
	localparam int TIME_W   = 62;
	localparam int PERIOD_W = 32;
	localparam int MISS_W   = 64;
	localparam int COV_W    = 16;

	// Coverage scale: percent times 256
	localparam logic signed [COV_W-1:0] FULL_Q8     = 16'sd25600;
	localparam logic signed [COV_W-1:0] NEG_FULL_Q8 = -16'sd25600;
	localparam logic [15:0]             TWICE_FULL_Q8 = 16'd51200;
	localparam int                      SCALE_BITS  = 16;
	localparam int                      BIT_W       = $clog2(SCALE_BITS);

	// Job queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Input item: one segment, or a bare window when no_segments is set
	typedef struct packed {
		logic                no_segments;
		logic                first_item;
		logic                last_item;
		logic [TIME_W-1:0]   seg_start_us;
		logic [TIME_W-1:0]   seg_end_us;
		logic [PERIOD_W-1:0] sample_period_us;
		logic [TIME_W-1:0]   window_start_us;
		logic [TIME_W-1:0]   window_end_us;
	} seg_item_t;

	// Result item
	typedef struct packed {
		logic signed [COV_W-1:0] coverage_q8;
		logic                    window_missed;
	} cov_item_t;

	// What the back end has to do for one waveform
	typedef enum logic [1:0] {
		JOB_MISSED = 2'd0,
		JOB_FULL   = 2'd1,
		JOB_CALC   = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t         kind;
		logic [MISS_W-1:0] missing;
		logic [TIME_W-1:0] length;
	} job_t;

	// Add with saturation at all ones
	function automatic logic [MISS_W-1:0] sat_add(input logic [MISS_W-1:0] a,
	                                              input logic [MISS_W-1:0] b);
		logic [MISS_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[MISS_W] ? {MISS_W{1'b1}} : sum[MISS_W-1:0];
	endfunction

endpackage

// ----- rtl/core/wcp_front.sv -----
// Front end: accepts segment items, tracks gaps and builds one job per waveform.
// Depends on wcp_pkg.

module wcp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               seg_valid,
	output logic               seg_stall,
	input  wcp_pkg::seg_item_t seg,
	output logic               push,
	output wcp_pkg::job_t      job,
	input  logic               full
);

	typedef enum logic [5:0] {
		F_IDLE = 6'b000001,
		F_CALC = 6'b000010,
		F_GAP  = 6'b000100,
		F_ACC  = 6'b001000,
		F_TAIL = 6'b010000,
		F_PUSH = 6'b100000
	} front_state_t;

	front_state_t state_q;

	// Latched window and per-waveform state
	logic [wcp_pkg::TIME_W-1:0] win_start_q, win_end_q;
	logic [wcp_pkg::MISS_W-1:0] missing_q, pending_q;
	logic [wcp_pkg::TIME_W:0]   lone_q;
	logic                       start_found_q, end_found_q, acc_q;
	logic [wcp_pkg::TIME_W-1:0] lie_q, prev_end_q;
	logic [wcp_pkg::MISS_W-1:0] thr_q;
	logic [1:0]                 seg_cnt_q;

	// Current item
	logic [wcp_pkg::TIME_W-1:0]   s_q, e_q;
	logic [wcp_pkg::PERIOD_W-1:0] p_q;
	logic                         last_q, none_q;

	// Compare stage results
	logic [wcp_pkg::TIME_W-1:0]   lone_a_s1, lone_b_s1, gap_s1;
	logic                         reach_s1, sle_s1, gap_ok_s1;
	logic [wcp_pkg::PERIOD_W+1:0] p3_s1;

	// Tail stage results
	logic [wcp_pkg::TIME_W-1:0] tail_s1, len_s1;
	logic                       eq_s1, rev_s1;

	logic accept, clr, found_new;
	logic [wcp_pkg::MISS_W-1:0] thr_item;

	assign seg_stall = (state_q != F_IDLE);
	assign accept    = seg_valid && (state_q == F_IDLE);
	assign push      = (state_q == F_PUSH) && !full;
	assign clr       = (accept && (seg.no_segments || seg.first_item)) || push;
	assign found_new = start_found_q || reach_s1;
	// 2*end + 3*period: an interior gap counts when 2*start exceeds this
	assign thr_item  = {1'b0, e_q, 1'b0} + {{(wcp_pkg::MISS_W-wcp_pkg::PERIOD_W-2){1'b0}}, p3_s1};

	// Build the job for the finished waveform
	always_comb begin
		job.length  = len_s1;
		job.missing = '0;
		job.kind    = wcp_pkg::JOB_MISSED;
		if (none_q) begin
			job.kind = wcp_pkg::JOB_MISSED;
		end else if (eq_s1) begin
			job.kind = wcp_pkg::JOB_FULL;
		end else if (seg_cnt_q == 2'd1) begin
			job.kind    = rev_s1 ? wcp_pkg::JOB_FULL : wcp_pkg::JOB_CALC;
			job.missing = {1'b0, lone_q};
		end else if (!start_found_q || !end_found_q) begin
			job.kind = wcp_pkg::JOB_MISSED;
		end else begin
			job.kind    = rev_s1 ? wcp_pkg::JOB_FULL : wcp_pkg::JOB_CALC;
			job.missing = wcp_pkg::sat_add(missing_q, {2'b00, tail_s1});
		end
	end

	// Sequence one item and update the waveform state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= F_IDLE;
			win_start_q   <= '0;
			win_end_q     <= '0;
			missing_q     <= '0;
			pending_q     <= '0;
			lone_q        <= '0;
			start_found_q <= 1'b0;
			end_found_q   <= 1'b0;
			acc_q         <= 1'b0;
			lie_q         <= '0;
			prev_end_q    <= '0;
			thr_q         <= '0;
			seg_cnt_q     <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (seg.no_segments || seg.first_item) begin
							win_start_q <= seg.window_start_us;
							win_end_q   <= seg.window_end_us;
						end
						state_q <= seg.no_segments ? F_TAIL : F_CALC;
					end
				end
				F_CALC: state_q <= F_GAP;
				F_GAP: begin
					if (seg_cnt_q == 2'd0) begin
						lone_q <= {1'b0, lone_a_s1} + {1'b0, lone_b_s1};
					end
					if (seg_cnt_q != 2'd2) begin
						seg_cnt_q <= seg_cnt_q + 2'd1;
					end
					acc_q <= start_found_q && sle_s1;
					if (!start_found_q) begin
						if (reach_s1) begin
							start_found_q <= 1'b1;
							missing_q     <= {2'b00, lone_a_s1};
							pending_q     <= '0;
							if (sle_s1) begin
								end_found_q <= 1'b1;
								lie_q       <= e_q;
							end
						end
					end else if (gap_ok_s1) begin
						pending_q <= wcp_pkg::sat_add(pending_q, {2'b00, gap_s1});
					end
					if (found_new) begin
						prev_end_q <= e_q;
						thr_q      <= thr_item;
					end
					state_q <= F_ACC;
				end
				F_ACC: begin
					// confirm pending gaps once a segment starts inside the window
					if (acc_q) begin
						missing_q   <= wcp_pkg::sat_add(missing_q, pending_q);
						pending_q   <= '0;
						end_found_q <= 1'b1;
						lie_q       <= e_q;
					end
					state_q <= last_q ? F_TAIL : F_IDLE;
				end
				F_TAIL: state_q <= F_PUSH;
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
			// drop the open waveform
			if (clr) begin
				missing_q     <= '0;
				pending_q     <= '0;
				lone_q        <= '0;
				start_found_q <= 1'b0;
				end_found_q   <= 1'b0;
				lie_q         <= '0;
				prev_end_q    <= '0;
				thr_q         <= '0;
				seg_cnt_q     <= '0;
			end
		end
	end

	// Item and compare registers
	always_ff @(posedge clk) begin
		if (accept) begin
			s_q    <= seg.seg_start_us;
			e_q    <= seg.seg_end_us;
			p_q    <= seg.sample_period_us;
			last_q <= seg.last_item;
			none_q <= seg.no_segments;
		end
		if (state_q == F_CALC) begin
			lone_a_s1 <= (s_q > win_start_q) ? s_q - win_start_q : '0;
			lone_b_s1 <= (e_q < win_end_q) ? win_end_q - e_q : '0;
			reach_s1  <= (e_q >= win_start_q);
			sle_s1    <= (s_q <= win_end_q);
			gap_s1    <= s_q - prev_end_q;
			gap_ok_s1 <= ({1'b0, s_q, 1'b0} > thr_q);
			p3_s1     <= {2'b00, p_q} + {1'b0, p_q, 1'b0};
		end
		if (state_q == F_TAIL) begin
			tail_s1 <= (lie_q <= win_end_q) ? win_end_q - lie_q : '0;
			len_s1  <= win_end_q - win_start_q;
			eq_s1   <= (win_end_q == win_start_q);
			rev_s1  <= (win_end_q < win_start_q);
		end
	end

endmodule

// ----- rtl/core/wcp_queue.sv -----
// Short job queue between the front and back ends.
// Depends on wcp_pkg.

module wcp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  wcp_pkg::job_t wr_job,
	output logic          full,
	input  logic          pop,
	output wcp_pkg::job_t rd_job,
	output logic          empty
);

	wcp_pkg::job_t                entry_q [wcp_pkg::QUEUE_DEPTH];
	logic [wcp_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [wcp_pkg::QUEUE_AW:0]   count_q;

	localparam logic [wcp_pkg::QUEUE_AW-1:0] LAST_PTR = wcp_pkg::QUEUE_AW'(wcp_pkg::QUEUE_DEPTH - 1);
	localparam logic [wcp_pkg::QUEUE_AW:0]   DEPTH_CNT = (wcp_pkg::QUEUE_AW + 1)'(wcp_pkg::QUEUE_DEPTH);

	assign full   = (count_q == DEPTH_CNT);
	assign empty  = (count_q == '0);
	assign rd_job = entry_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("job pushed into a full queue");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("job popped from an empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= DEPTH_CNT)
		else $error("queue count beyond its depth");

endmodule

// ----- rtl/core/wcp_back.sv -----
// Back end: turns a job into a coverage result with a shared compare-subtract unit.
// Depends on wcp_pkg.

module wcp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               pop,
	input  wcp_pkg::job_t      job,
	output logic               cov_valid,
	input  logic               cov_stall,
	output wcp_pkg::cov_item_t cov
);

	typedef enum logic [6:0] {
		B_IDLE = 7'b0000001,
		B_CHK  = 7'b0000010,
		B_RED  = 7'b0000100,
		B_DBL  = 7'b0001000,
		B_ADD  = 7'b0010000,
		B_TOT  = 7'b0100000,
		B_FIN  = 7'b1000000
	} back_state_t;

	back_state_t state_q;

	logic [wcp_pkg::MISS_W-1:0]  m_q;
	logic [wcp_pkg::TIME_W-1:0]  d_q, r_q, x_q;
	logic [15:0]                 q_q;
	logic                        q0_q;
	logic [wcp_pkg::BIT_W-1:0]   bit_q;
	logic [wcp_pkg::COV_W-1:0]   cov_q;
	logic                        missed_q;
	logic                        cov_valid_q;
	wcp_pkg::cov_item_t          cov_out_q;

	logic [wcp_pkg::TIME_W:0]    y, y_diff;
	logic                        y_ge;
	logic                        load;
	logic [16:0]                 t;
	logic [17:0]                 t_up;
	logic [17:0]                 cov_wide;

	assign pop       = (state_q == B_IDLE) && job_valid;
	assign load      = (state_q == B_FIN) && (!cov_valid_q || !cov_stall);
	assign cov_valid = cov_valid_q;
	assign cov       = cov_out_q;

	// Shared compare-subtract on the running remainder
	always_comb begin
		if (state_q == B_DBL) begin
			y = {x_q, 1'b0};
		end else begin
			y = {1'b0, x_q} + (wcp_pkg::TWICE_FULL_Q8[bit_q] ? {1'b0, r_q} : '0);
		end
		y_ge   = (y >= {1'b0, d_q});
		y_diff = y - {1'b0, d_q};
	end

	// Round the missing share half up and subtract from full coverage
	always_comb begin
		t        = {1'b0, q_q} + (q0_q ? {1'b0, wcp_pkg::TWICE_FULL_Q8} : 17'd0);
		t_up     = {1'b0, t} + 18'd1;
		cov_wide = {2'b00, wcp_pkg::FULL_Q8} - {1'b0, t_up[17:1]};
	end

	// Control sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cov_valid_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						state_q <= (job.kind == wcp_pkg::JOB_CALC) ? B_CHK : B_FIN;
					end
				end
				B_CHK:   state_q <= (m_q >= {1'b0, d_q, 1'b0}) ? B_FIN : B_RED;
				B_RED:   state_q <= B_DBL;
				B_DBL:   state_q <= B_ADD;
				B_ADD:   state_q <= (bit_q == '0) ? B_TOT : B_DBL;
				B_TOT:   state_q <= B_FIN;
				B_FIN: begin
					if (load) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
			if (load) begin
				cov_valid_q <= 1'b1;
			end else if (!cov_stall) begin
				cov_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				m_q      <= job.missing;
				d_q      <= job.length;
				missed_q <= (job.kind == wcp_pkg::JOB_MISSED);
				case (job.kind)
					wcp_pkg::JOB_FULL: cov_q <= wcp_pkg::FULL_Q8;
					default:           cov_q <= '0;
				endcase
			end
			B_CHK: begin
				cov_q <= wcp_pkg::NEG_FULL_Q8;
			end
			B_RED: begin
				if (m_q >= {2'b00, d_q}) begin
					r_q  <= m_q[wcp_pkg::TIME_W-1:0] - d_q;
					q0_q <= 1'b1;
				end else begin
					r_q  <= m_q[wcp_pkg::TIME_W-1:0];
					q0_q <= 1'b0;
				end
				x_q   <= '0;
				q_q   <= '0;
				bit_q <= wcp_pkg::BIT_W'(wcp_pkg::SCALE_BITS - 1);
			end
			B_DBL: begin
				x_q <= y_ge ? y_diff[wcp_pkg::TIME_W-1:0] : y[wcp_pkg::TIME_W-1:0];
				q_q <= {q_q[14:0], y_ge};
			end
			B_ADD: begin
				x_q   <= y_ge ? y_diff[wcp_pkg::TIME_W-1:0] : y[wcp_pkg::TIME_W-1:0];
				q_q   <= q_q + {15'd0, y_ge};
				bit_q <= bit_q - 1'b1;
			end
			B_TOT: begin
				cov_q <= cov_wide[wcp_pkg::COV_W-1:0];
			end
			default: begin
			end
		endcase
		if (load) begin
			cov_out_q.coverage_q8   <= cov_q;
			cov_out_q.window_missed <= missed_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DBL || state_q == B_ADD) |-> (x_q < d_q))
		else $error("division remainder not below the window length");
	assert property (@(posedge clk) disable iff (!arst_n)
		cov_valid |-> (cov.coverage_q8 >= wcp_pkg::NEG_FULL_Q8 &&
		               cov.coverage_q8 <= wcp_pkg::FULL_Q8))
		else $error("coverage out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cov_valid && cov.window_missed) |-> (cov.coverage_q8 == '0))
		else $error("missed window with nonzero coverage");

endmodule

// ----- rtl/core/window_coverage_percent.sv -----
// Top level of the window coverage block: front end, job queue, back end.
// Depends on wcp_pkg, wcp_front, wcp_queue and wcp_back.
//
//   channel  dir  handshake            payload
//   seg      in   seg_valid/seg_stall  wcp_pkg::seg_item_t, one segment or bare window
//   cov      out  cov_valid/cov_stall  wcp_pkg::cov_item_t, one per waveform
//
// A segment item passes the front-end states take, compare, gap update and commit;
// a last item then closes the waveform and queues its job, as does a no-segment item.
// The back end works out 16 quotient bits, each by a double and an add step on one
// compare-subtract unit; a saturated coverage ends after the check, a forced one skips it.
// Reset clears all control state and the front end's accumulators at once; there is no clearing pass.
// A stall on cov holds the result register; the back end then waits, the two-job queue
// fills, and the front end raises seg_stall until a slot frees.

module window_coverage_percent (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               seg_valid,
	output logic               seg_stall,
	input  wcp_pkg::seg_item_t seg,
	output logic               cov_valid,
	input  logic               cov_stall,
	output wcp_pkg::cov_item_t cov
);

	logic          push, full, pop, empty;
	wcp_pkg::job_t wr_job, rd_job;

	wcp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.seg       (seg),
		.push      (push),
		.job       (wr_job),
		.full      (full)
	);

	wcp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.full   (full),
		.pop    (pop),
		.rd_job (rd_job),
		.empty  (empty)
	);

	wcp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!empty),
		.pop       (pop),
		.job       (rd_job),
		.cov_valid (cov_valid),
		.cov_stall (cov_stall),
		.cov       (cov)
	);

endmodule

// ----- tb/sv/tb_window_coverage_percent.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for window_coverage_percent: segment streams in, coverage out.
// Depends on wcp_pkg and the window_coverage_percent RTL; it carries its own coverage predictor.

module tb_window_coverage_percent;

	typedef logic [63:0] u64;

	localparam u64          TIME_MAX    = 64'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [31:0] PERIOD_MAX  = 32'hFFFF_FFFF;
	localparam int          HOLD_CYCLES = 400;
	localparam int          DRAIN       = 100;
	localparam int          LIMIT       = 1_000_000;

	logic               clk;
	logic               arst_n;
	logic               seg_valid;
	logic               seg_stall;
	wcp_pkg::seg_item_t seg;
	logic               cov_valid;
	logic               cov_stall;
	wcp_pkg::cov_item_t cov;

	// Predictor state for the open waveform
	u64          win_lo, win_hi, miss_sum, held_gap, lone_gap, tail_end, prior_end;
	logic [31:0] prior_period;
	bit          start_seen, end_seen;
	int          seg_cnt;

	wcp_pkg::cov_item_t coverage_expected[$];
	int                 mismatches;
	int                 items_sent;
	int                 cycles;
	bit                 steady;
	bit                 hold_req;
	bit                 hold_on;

	window_coverage_percent u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.seg       (seg),
		.cov_valid (cov_valid),
		.cov_stall (cov_stall),
		.cov       (cov)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bound the run
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= LIMIT) begin
				$display("window_coverage_percent: mismatch");
				$finish;
			end
		end
	end

	function automatic u64 rand_time();
		return {$urandom, $urandom} & TIME_MAX;
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady) return 0;
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic u64 add_sat(input u64 a, input u64 b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction

	function automatic void reset_accumulators();
		miss_sum     = '0;
		start_seen   = 1'b0;
		end_seen     = 1'b0;
		tail_end     = '0;
		prior_end    = '0;
		prior_period = '0;
		held_gap     = '0;
		lone_gap     = '0;
		seg_cnt      = 0;
	endfunction

	// Coverage in q8 for a given missing time over the latched window
	function automatic logic signed [15:0] coverage_from(input u64 missing);
		u64          span;
		logic [79:0] scaled;
		int          half_up;
		int          q;
		span = win_hi - win_lo;
		if (missing >= 2 * span) return wcp_pkg::NEG_FULL_Q8;
		scaled = ({16'd0, missing} * {64'd0, wcp_pkg::TWICE_FULL_Q8}) / {16'd0, span};
		half_up = int'((scaled + 80'd1) >> 1);
		q = int'(wcp_pkg::FULL_Q8) - half_up;
		if (q < int'(wcp_pkg::NEG_FULL_Q8)) q = int'(wcp_pkg::NEG_FULL_Q8);
		return q[15:0];
	endfunction

	// Advance the predictor by one item; return 1 when a result is due
	function automatic bit predict_coverage(input wcp_pkg::seg_item_t it,
	                                        output wcp_pkg::cov_item_t res);
		u64          s, e, gap, m;
		logic [31:0] p;
		s = u64'(it.seg_start_us);
		e = u64'(it.seg_end_us);
		p = it.sample_period_us;
		res.coverage_q8   = '0;
		res.window_missed = 1'b0;
		if (it.no_segments) begin
			win_lo = u64'(it.window_start_us);
			win_hi = u64'(it.window_end_us);
			reset_accumulators();
			res.window_missed = 1'b1;
			return 1'b1;
		end
		if (it.first_item) begin
			win_lo = u64'(it.window_start_us);
			win_hi = u64'(it.window_end_us);
			reset_accumulators();
		end
		// edge gaps of the first segment, used if it stays alone
		if (seg_cnt == 0)
			lone_gap = (s > win_lo ? s - win_lo : 64'd0) + (e < win_hi ? win_hi - e : 64'd0);
		if (seg_cnt < 2) seg_cnt++;
		if (!start_seen) begin
			if (e >= win_lo) begin
				start_seen = 1'b1;
				if (s >= win_lo) miss_sum = add_sat(miss_sum, s - win_lo);
				held_gap = '0;
				if (s <= win_hi) begin
					end_seen = 1'b1;
					tail_end = e;
				end
			end
		end else begin
			// hold interior gaps until a later segment starts inside the window
			if (s > prior_end) begin
				gap = s - prior_end;
				if (2 * gap > 3 * u64'(prior_period)) held_gap = add_sat(held_gap, gap);
			end
			if (s <= win_hi) begin
				miss_sum = add_sat(miss_sum, held_gap);
				held_gap = '0;
				end_seen = 1'b1;
				tail_end = e;
			end
		end
		if (start_seen) begin
			prior_end    = e;
			prior_period = p;
		end
		if (!it.last_item) return 1'b0;
		if (win_hi == win_lo) begin
			res.coverage_q8 = wcp_pkg::FULL_Q8;
		end else if (seg_cnt == 1) begin
			res.coverage_q8 = (win_hi < win_lo) ? wcp_pkg::FULL_Q8 : coverage_from(lone_gap);
		end else if (!start_seen || !end_seen) begin
			res.window_missed = 1'b1;
		end else begin
			m = miss_sum;
			if (tail_end <= win_hi) m = add_sat(m, win_hi - tail_end);
			res.coverage_q8 = (win_hi < win_lo) ? wcp_pkg::FULL_Q8 : coverage_from(m);
		end
		reset_accumulators();
		return 1'b1;
	endfunction

	function automatic wcp_pkg::seg_item_t make_item(input bit none, input bit first,
	                                                 input bit last, input u64 s, input u64 e,
	                                                 input logic [31:0] p,
	                                                 input u64 ws, input u64 we);
		wcp_pkg::seg_item_t it;
		it.no_segments      = none;
		it.first_item       = first;
		it.last_item        = last;
		it.seg_start_us     = s[wcp_pkg::TIME_W-1:0];
		it.seg_end_us       = e[wcp_pkg::TIME_W-1:0];
		it.sample_period_us = p;
		it.window_start_us  = ws[wcp_pkg::TIME_W-1:0];
		it.window_end_us    = we[wcp_pkg::TIME_W-1:0];
		return it;
	endfunction

	// Offer one item after a random gap, wait for acceptance, then predict
	task automatic send_item(input wcp_pkg::seg_item_t it);
		int                 gap;
		wcp_pkg::cov_item_t res;
		gap = idle_len();
		if (gap > 0) begin
			seg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		seg       <= it;
		seg_valid <= 1'b1;
		@(posedge clk);
		while (seg_stall) @(posedge clk);
		items_sent++;
		if (predict_coverage(it, res))
			coverage_expected.insert(coverage_expected.size(), res);
	endtask

	// Stop offering and wait until every expected result has come
	task automatic drain_results();
		seg_valid <= 1'b0;
		do @(posedge clk); while (coverage_expected.size() != 0);
	endtask

	// One well-formed waveform with random content around a random window
	task automatic send_waveform(input int nseg);
		u64 base, sc, ws, we, t, s, e, tmp;
		int i;
		if ($urandom_range(0, 7) == 0) base = u64'($urandom_range(0, 100));
		else base = rand_time() >> $urandom_range(2, 40);
		sc = u64'($urandom_range(1, 2000));
		ws = base + sc * $urandom_range(0, 20);
		we = ws + sc * $urandom_range(0, 60);
		if ($urandom_range(0, 15) == 0) begin
			tmp = ws;
			ws  = we;
			we  = tmp;
		end
		t = base;
		for (i = 0; i < nseg; i++) begin
			// mostly forward, sometimes overlapping the previous segment
			if ($urandom_range(0, 7) == 0 && t > sc) s = t - $urandom_range(0, 32'(sc));
			else s = t + $urandom_range(0, 32'(3 * sc));
			e = s + sc * $urandom_range(0, 15);
			send_item(make_item(1'b0, i == 0, i == nseg - 1, s, e, $urandom_range(1, 32'(sc)),
			                    ws, we));
			t = e;
		end
	endtask

	task automatic random_waveform();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			send_item(make_item(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			                    rand_time(), rand_time(), $urandom_range(1, PERIOD_MAX),
			                    rand_time(), rand_time()));
		else if (r == 1)
			send_waveform(1);
		else if (r == 2)
			send_waveform($urandom_range(8, 12));
		else
			send_waveform($urandom_range(2, 6));
	endtask

	task automatic test_directed();
		int k;
		// no segments: all-ones fields but a zero window end, then zero times with both marks
		send_item(make_item(1'b1, 1'b0, 1'b0, TIME_MAX, TIME_MAX, PERIOD_MAX, TIME_MAX, 0));
		send_item(make_item(1'b1, 1'b1, 1'b1, 0, 0, 1, 0, 0));
		// lone segments: zero-length, inside, reversed window, far outside, rounding tie
		send_item(make_item(1'b0, 1'b1, 1'b1, 100, 200, 10, 500, 500));
		send_item(make_item(1'b0, 1'b1, 1'b1, 1200, 1900, 10, 1000, 2000));
		send_item(make_item(1'b0, 1'b1, 1'b1, 1200, 1900, 10, 2000, 1000));
		send_item(make_item(1'b0, 1'b1, 1'b1, 1000, 2000, PERIOD_MAX, 0, 100));
		send_item(make_item(1'b0, 1'b1, 1'b1, 1, 51200, 1, 0, 51200));
		// short gap ignored, long gap counted, end gap added
		send_item(make_item(1'b0, 1'b1, 1'b0, 0, 3000, 10, 0, 10000));
		send_item(make_item(1'b0, 1'b0, 1'b0, 3010, 6000, 10, 0, 10000));
		send_item(make_item(1'b0, 1'b0, 1'b1, 6100, 9000, 10, 0, 10000));
		// window never reached: all before start, then all after end
		send_item(make_item(1'b0, 1'b1, 1'b0, 0, 100, 5, 10000, 20000));
		send_item(make_item(1'b0, 1'b0, 1'b1, 200, 300, 5, 10000, 20000));
		send_item(make_item(1'b0, 1'b1, 1'b0, 200, 300, 5, 0, 100));
		send_item(make_item(1'b0, 1'b0, 1'b1, 400, 500, 5, 0, 100));
		// no first mark after a result: reuse the latched window
		send_item(make_item(1'b0, 1'b0, 1'b0, 20, 60, 3, TIME_MAX, 0));
		send_item(make_item(1'b0, 1'b0, 1'b1, 70, 90, 3, TIME_MAX, 0));
		// first mark inside an open waveform drops it
		send_item(make_item(1'b0, 1'b1, 1'b0, 10, 40, 2, 0, 100));
		send_item(make_item(1'b0, 1'b1, 1'b1, 10, 90, 2, 0, 100));
		// saturate the missing sum with huge gaps inside a full window
		send_item(make_item(1'b0, 1'b1, 1'b0, 0, 0, 1, 0, TIME_MAX));
		for (k = 0; k < 4; k++)
			send_item(make_item(1'b0, 1'b0, 1'b0, TIME_MAX, 0, 1, 0, TIME_MAX));
		send_item(make_item(1'b0, 1'b0, 1'b1, TIME_MAX, 0, 1, 0, TIME_MAX));
		drain_results();
	endtask

	task automatic test_random_waveforms();
		while (items_sent < 1150) random_waveform();
		drain_results();
	endtask

	// Hold the result side for a long stretch while items keep coming
	task automatic test_backpressure();
		int k;
		steady   = 1'b1;
		hold_req = 1'b1;
		while (!hold_on) @(posedge clk);
		for (k = 0; k < 12; k++) send_waveform($urandom_range(2, 5));
		steady = 1'b0;
		drain_results();
	endtask

	task automatic test_steady_stream();
		int k;
		steady = 1'b1;
		for (k = 0; k < 30; k++) random_waveform();
		drain_results();
		steady = 1'b0;
	endtask

	// Random marks and full-range fields, mixed with proper waveforms
	task automatic test_broken_sequences();
		int sh;
		while (items_sent < 1650) begin
			if ($urandom_range(0, 3) == 0) begin
				random_waveform();
			end else begin
				sh = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(40, 58);
				send_item(make_item($urandom_range(0, 7) == 0, $urandom_range(0, 2) == 0,
				                    $urandom_range(0, 2) == 0, rand_time() >> sh,
				                    rand_time() >> sh, $urandom_range(1, PERIOD_MAX),
				                    rand_time() >> sh, rand_time() >> sh));
			end
		end
		drain_results();
	endtask

	// Result side: random stalls, or one long hold on request
	initial begin : cov_sink
		int run;
		cov_stall <= 1'b0;
		hold_on = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				hold_on  = 1'b1;
				cov_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_on = 1'b0;
				cov_stall <= 1'b0;
				@(posedge clk);
			end else begin
				run = idle_len();
				if (run > 0) begin
					cov_stall <= 1'b1;
					repeat (run) @(posedge clk);
				end
				cov_stall <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// Compare each accepted result with the oldest expectation
	initial begin : cov_check
		wcp_pkg::cov_item_t want;
		forever begin
			@(posedge clk);
			if (arst_n && cov_valid && !cov_stall) begin
				if (coverage_expected.size() == 0) begin
					$error("unexpected result: coverage_q8 %0d window_missed %0b",
					       cov.coverage_q8, cov.window_missed);
					mismatches++;
				end else begin
					want = coverage_expected.pop_front();
					if (cov.coverage_q8 !== want.coverage_q8) begin
						$error("coverage_q8: expected %0d, got %0d",
						       want.coverage_q8, cov.coverage_q8);
						mismatches++;
					end
					if (cov.window_missed !== want.window_missed) begin
						$error("window_missed: expected %0b, got %0b",
						       want.window_missed, cov.window_missed);
						mismatches++;
					end
				end
			end
		end
	end

	// Reset, run the tests in turn, then report
	initial begin
		mismatches = 0;
		items_sent = 0;
		steady     = 1'b0;
		hold_req   = 1'b0;
		win_lo     = '0;
		win_hi     = '0;
		reset_accumulators();
		arst_n    <= 1'b0;
		seg_valid <= 1'b0;
		seg       <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_waveforms();
		test_backpressure();
		test_steady_stream();
		test_broken_sequences();
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0 && coverage_expected.size() == 0)
			$display("window_coverage_percent: match");
		else
			$display("window_coverage_percent: mismatch");
		$finish;
	end

endmodule
